// ===== sv/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
`default_nettype none
package spq_pkg;

  localparam int DEPTH       = 256;
  localparam int HANDLE_BITS = 9;
  localparam int FREQ_BITS   = 32;
  localparam int COUNT_BITS  = $clog2(DEPTH + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic                   operation;
    logic [HANDLE_BITS-1:0] node_handle;
    logic [FREQ_BITS-1:0]   frequency;
  } spq_in_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] removed_handle;
    logic [FREQ_BITS-1:0]   removed_frequency;
    logic                   removed_valid;
    logic                   insert_dropped;
    logic [COUNT_BITS-1:0]  entry_count;
    logic                   exactly_one;
  } spq_out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                   ins;
    logic                   pop;
    logic [HANDLE_BITS-1:0] handle;
    logic [FREQ_BITS-1:0]   freq;
  } spq_ctl_t;

endpackage
`default_nettype wire

// ===== sv/spq_cell.sv =====
// one queue position: holds an entry, shifts toward the tail on insert, toward the head on pop
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  logic                   clk,
  input  spq_ctl_t               ctl,
  input  logic                   head,
  input  logic                   occupied,
  input  logic                   prev_shift,
  input  logic [FREQ_BITS-1:0]   prev_key,
  input  logic [HANDLE_BITS-1:0] prev_handle,
  input  logic [FREQ_BITS-1:0]   next_key,
  input  logic [HANDLE_BITS-1:0] next_handle,
  output logic                   shift,
  output logic [FREQ_BITS-1:0]   key,
  output logic [HANDLE_BITS-1:0] handle
);

  logic key_ge;

  // the head yields only to a strictly smaller key, later cells also on a tie
  assign key_ge = head ? (key > ctl.freq) : (key >= ctl.freq);
  assign shift  = !occupied || key_ge;

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      key    <= next_key;
      handle <= next_handle;
    end else if (ctl.ins && shift) begin
      if (prev_shift) begin
        key    <= prev_key;
        handle <= prev_handle;
      end else begin
        key    <= ctl.freq;
        handle <= ctl.handle;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/sorted_priority_queue_top.sv =====
// sorted priority queue: a chain of entry cells kept in ascending frequency order
// usage:
//   req carries one item: an insert (handle and frequency) or a remove of the head.
//   rsp returns one item per request: the popped head (or an empty flag), a drop
//   flag for an insert into a full queue, and the entry count after the operation.
//   every cell compares its key with the incoming frequency in parallel, so an
//   insert or a pop finishes in the cycle it is accepted; the shift happens across
//   the whole chain at that clock edge.
//   latency: the response is registered and appears the cycle after acceptance.
//   throughput: one item per cycle while the receiver takes responses.
//   when the receiver stalls, the response register holds and req_ready drops
//   until the waiting item is taken; no state changes meanwhile.
//   reset clears the entry count and the response valid; cell contents are not
//   cleared, entries at or beyond the count are never read.
`default_nettype none
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  spq_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output spq_out_t rsp
);

  logic                   acc;
  logic                   full;
  logic                   empty;
  logic [COUNT_BITS-1:0]  count;
  logic [COUNT_BITS-1:0]  count_next;
  spq_ctl_t               ctl;
  spq_out_t               rsp_next;

  logic [FREQ_BITS-1:0]   cell_key    [DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
  logic                   cell_shift  [DEPTH];

  assign req_ready = !rsp_valid || rsp_ready;
  assign acc       = req_valid && req_ready;
  assign full      = (count == COUNT_BITS'(DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    ctl.ins    = acc && (req.operation == OP_INSERT) && !full;
    ctl.pop    = acc && (req.operation == OP_REMOVE) && !empty;
    ctl.handle = req.node_handle;
    ctl.freq   = req.frequency;
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                   p_shift;
      logic [FREQ_BITS-1:0]   p_key;
      logic [HANDLE_BITS-1:0] p_handle;
      logic [FREQ_BITS-1:0]   n_key;
      logic [HANDLE_BITS-1:0] n_handle;

      if (gi == 0) begin : g_first
        assign p_shift  = 1'b0;
        assign p_key    = req.frequency;
        assign p_handle = req.node_handle;
      end else begin : g_mid
        assign p_shift  = cell_shift[gi-1];
        assign p_key    = cell_key[gi-1];
        assign p_handle = cell_handle[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign n_key    = cell_key[gi];
        assign n_handle = cell_handle[gi];
      end else begin : g_inner
        assign n_key    = cell_key[gi+1];
        assign n_handle = cell_handle[gi+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .head       (gi == 0),
        .occupied   (COUNT_BITS'(gi) < count),
        .prev_shift (p_shift),
        .prev_key   (p_key),
        .prev_handle(p_handle),
        .next_key   (n_key),
        .next_handle(n_handle),
        .shift      (cell_shift[gi]),
        .key        (cell_key[gi]),
        .handle     (cell_handle[gi])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + COUNT_BITS'(1);
    end else if (ctl.pop) begin
      count_next = count - COUNT_BITS'(1);
    end
    rsp_next.removed_handle    = ctl.pop ? cell_handle[0] : '0;
    rsp_next.removed_frequency = ctl.pop ? cell_key[0] : '0;
    rsp_next.removed_valid     = ctl.pop;
    rsp_next.insert_dropped    = (req.operation == OP_INSERT) && full;
    rsp_next.entry_count       = count_next;
    rsp_next.exactly_one       = (count_next == COUNT_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (acc) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (acc) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(DEPTH))
    else $error("entry count beyond depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= COUNT_BITS'(2) |-> cell_key[0] <= cell_key[1])
    else $error("head key above second key");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + COUNT_BITS'(1))
    else $error("insert did not grow the count");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> rsp_valid && rsp.entry_count == count)
    else $error("response missing or count mismatch");

  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> rsp.removed_valid && !rsp.insert_dropped)
    else $error("pop not reported");

endmodule
`default_nettype wire

// ===== bench/sorted_priority_queue_checker.sv =====
// checker for the sorted priority queue: predicts every response and compares it
`timescale 1ns / 1ps
module sorted_priority_queue_checker
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_ready,
  input  spq_in_t  req,
  input  logic     rsp_valid,
  input  logic     rsp_ready,
  input  spq_out_t rsp,
  output int       mismatches,
  output int       pending
);

  // shadow copy of the queue, head at index 0
  logic [FREQ_BITS-1:0]   key_mem    [DEPTH];
  logic [HANDLE_BITS-1:0] handle_mem [DEPTH];
  int                     held;

  spq_out_t predicted_rsp_q [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    held       = 0;
  end

  function automatic spq_out_t predict_queue_op(input spq_in_t it);
    spq_out_t r;
    int       pos;
    r = '0;
    if (it.operation == OP_INSERT) begin
      if (held >= DEPTH) begin
        r.insert_dropped = 1'b1;
      end else begin
        // an equal key never displaces the head
        if (held == 0 || it.frequency < key_mem[0]) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < held && it.frequency > key_mem[pos]) pos++;
        end
        for (int i = held; i > pos; i--) begin
          key_mem[i]    = key_mem[i-1];
          handle_mem[i] = handle_mem[i-1];
        end
        key_mem[pos]    = it.frequency;
        handle_mem[pos] = it.node_handle;
        held++;
      end
    end else if (held > 0) begin
      r.removed_handle    = handle_mem[0];
      r.removed_frequency = key_mem[0];
      r.removed_valid     = 1'b1;
      for (int i = 0; i < held - 1; i++) begin
        key_mem[i]    = key_mem[i+1];
        handle_mem[i] = handle_mem[i+1];
      end
      held--;
    end
    r.entry_count = COUNT_BITS'(held);
    r.exactly_one = (held == 1);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    spq_out_t exp_r;
    if (rst) begin
      held = 0;
      predicted_rsp_q.delete();
    end else begin
      if (req_valid && req_ready) predicted_rsp_q.push_back(predict_queue_op(req));
      if (rsp_valid && rsp_ready) begin
        if (predicted_rsp_q.size() == 0) begin
          $display("%0t: response expected none actual %h", $time, rsp);
          mismatches++;
        end else begin
          exp_r = predicted_rsp_q.pop_front();
          check_field("removed_handle", 32'(exp_r.removed_handle),
                      32'(rsp.removed_handle));
          check_field("removed_frequency", exp_r.removed_frequency,
                      rsp.removed_frequency);
          check_field("removed_valid", 32'(exp_r.removed_valid),
                      32'(rsp.removed_valid));
          check_field("insert_dropped", 32'(exp_r.insert_dropped),
                      32'(rsp.insert_dropped));
          check_field("entry_count", 32'(exp_r.entry_count), 32'(rsp.entry_count));
          check_field("exactly_one", 32'(exp_r.exactly_one), 32'(rsp.exactly_one));
        end
      end
    end
    pending <= predicted_rsp_q.size();
  end

endmodule

// ===== bench/sorted_priority_queue_top_tb.sv =====
// testbench top for the sorted priority queue: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam int QUIET_TAIL  = 150;
  localparam int IDLE_LIMIT  = 1000;
  localparam int LONG_HOLD   = 80;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  spq_in_t  req       = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  spq_out_t rsp;

  int mismatches;
  int pending;
  int items_sent  = 0;
  bit quiet       = 1'b0;
  int rsp_taken   = 0;
  int stall_left  = 0;
  int holds_done  = 0;
  int idle_cycles = 0;

  sorted_priority_queue_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  sorted_priority_queue_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls plus two long hold-offs so the queue input backs up
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_taken <= rsp_taken + 1;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_ready  <= 1'b0;
      end else if (holds_done < 2 && rsp_taken >= (holds_done + 1) * 500) begin
        stall_left <= LONG_HOLD - 1;
        holds_done <= holds_done + 1;
        rsp_ready  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 4);
        rsp_ready  <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic spq_in_t pack_item(input logic op, input logic [HANDLE_BITS-1:0] h,
                                        input logic [FREQ_BITS-1:0] f);
    spq_in_t it;
    it.operation   = op;
    it.node_handle = h;
    it.frequency   = f;
    return it;
  endfunction

  // narrow keys force lots of equal-frequency placements
  function automatic spq_in_t random_item(input int insert_pct, input bit narrow_keys);
    logic [FREQ_BITS-1:0] f;
    int                   pick;
    pick = $urandom_range(0, 9);
    if (narrow_keys) f = $urandom_range(0, 3);
    else if (pick < 5) f = $urandom;
    else if (pick < 8) f = $urandom_range(0, 15);
    else if (pick == 8) f = '0;
    else f = '1;
    return pack_item(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                     HANDLE_BITS'($urandom_range(0, 511)), f);
  endfunction

  task automatic send_item(input spq_in_t it);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
    quiet = (ITEM_TARGET + 20 - items_sent) < QUIET_TAIL;
  endtask

  task automatic wait_all_answered();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int phase;
    int len;
    int ins_pct;
    bit narrow;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pop, head cases, equal keys, extreme fields, drain past empty
    send_item(pack_item(OP_REMOVE, 9'h1ff, 32'hffff_ffff));
    send_item(pack_item(OP_INSERT, 9'h000, 32'd100));
    send_item(pack_item(OP_INSERT, 9'h001, 32'd100));
    send_item(pack_item(OP_INSERT, 9'h1ff, 32'd50));
    send_item(pack_item(OP_INSERT, 9'h002, 32'h0000_0000));
    send_item(pack_item(OP_INSERT, 9'h003, 32'hffff_ffff));
    send_item(pack_item(OP_INSERT, 9'h004, 32'd100));
    send_item(pack_item(OP_INSERT, 9'h005, 32'd75));
    send_item(pack_item(OP_INSERT, 9'h1aa, 32'h5555_5555));
    send_item(pack_item(OP_INSERT, 9'h155, 32'haaaa_aaaa));
    send_item(pack_item(OP_INSERT, 9'h0f0, 32'h0000_0000));
    repeat (11) send_item(pack_item(OP_REMOVE, 9'h000, 32'h0000_0000));
    send_item(pack_item(OP_INSERT, 9'h0aa, 32'hffff_ffff));
    send_item(pack_item(OP_INSERT, 9'h155, 32'hffff_ffff));
    send_item(pack_item(OP_REMOVE, 9'h0ff, 32'h1234_5678));
    wait_all_answered();

    // random phases: fill past full, drain past empty, then a mix
    phase = 0;
    while (items_sent < ITEM_TARGET + 20) begin
      narrow = 1'b0;
      if (phase == 0) begin
        len = 320; ins_pct = 95;
      end else if (phase == 1) begin
        len = 320; ins_pct = 5;
      end else begin
        len = $urandom_range(30, 150);
        case ($urandom_range(0, 3))
          0: begin ins_pct = 85; end
          1: begin ins_pct = 15; end
          2: begin ins_pct = 50; end
          default: begin ins_pct = 60; narrow = 1'b1; end
        endcase
      end
      for (int i = 0; i < len && items_sent < ITEM_TARGET + 20; i++)
        send_item(random_item(ins_pct, narrow));
      if (!quiet && $urandom_range(0, 3) == 0) wait_all_answered();
      phase++;
    end

    wait_all_answered();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
